// ===== hdl/mandelbrot_escape_time_core_macros.svh =====
// assertion macros for the mandelbrot escape time core
// used by the top level only, no other dependencies
`ifndef MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MET_ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("same cycle check failed");
`define MET_ASSERT_NXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("next cycle check failed");
`else
`define MET_ASSERT_IMP(lbl, ck, rn, a, c)
`define MET_ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

// ===== hdl/met_pkg.sv =====
// shared types and constants of the mandelbrot escape time core
// no dependencies
`timescale 1ns / 1ps
package met_pkg;
	localparam int unsigned ITERATION_LIMIT = 4000;
	localparam int unsigned PIX_BITS = 12;
	localparam int unsigned CNT_BITS = 12;

	localparam logic [1:0] CFG_X_OFFSET = 2'd0;
	localparam logic [1:0] CFG_Y_OFFSET = 2'd1;
	localparam logic [1:0] CFG_ZOOM = 2'd2;
	localparam logic [1:0] CFG_MAX_ITER = 2'd3;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_RES,
		B_UPD1,
		B_UPD2,
		B_CHK,
		B_GRAY,
		B_FIN
	} back_state_t;

	typedef enum logic [2:0] {
		OP_RR0,
		OP_II0,
		OP_RI,
		OP_RR,
		OP_II
	} mul_op_t;

	typedef struct packed {
		logic [7:0] gray;
		logic [CNT_BITS-1:0] count;
		logic [PIX_BITS-1:0] row;
		logic [PIX_BITS-1:0] col;
	} result_t;
endpackage

// ===== hdl/met_front.sv =====
// front end: accepts pixels and maps them to plane coordinates by long division
// depends on met_pkg
`timescale 1ns / 1ps
module met_front import met_pkg::*; #(
	parameter int FRACTION_BITS = 40
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [PIX_BITS-1:0] column,
	input  logic [PIX_BITS-1:0] row,
	input  logic [31:0] x_offset,
	input  logic [31:0] y_offset,
	input  logic [30:0] zoom_divisor,
	output logic out_valid,
	input  logic out_ready,
	output logic [2*PIX_BITS+2*(FRACTION_BITS+8)-1:0] out_data
);
	localparam int W = FRACTION_BITS + 8;
	localparam int M = FRACTION_BITS + 7;
	localparam int DN = 33 + FRACTION_BITS;
	localparam int CW = $clog2(DN);

	front_state_t state_q, state_d;
	logic [CW-1:0] step_q;
	logic [PIX_BITS-1:0] col_q, row_q;
	logic [32:0] dx_q, dy_q;
	logic [30:0] rx_q, ry_q;
	logic [DN-1:0] qx_q, qy_q;
	logic sx_q, sy_q;
	logic [30:0] zoom;
	logic signed [32:0] sum_x, sum_y;
	logic [31:0] tx, ty;
	logic gex, gey;

	function automatic logic [W-1:0] coord(input logic [DN-1:0] q, input logic neg);
		logic [W-1:0] v;
		if (q[DN-1:FRACTION_BITS] > 33'd127) v = {1'b0, {M{1'b1}}};
		else v = {1'b0, q[M-1:0]};
		return neg ? -v : v;
	endfunction

	assign zoom = (zoom_divisor == 31'd0) ? 31'd1 : zoom_divisor;
	assign sum_x = $signed({21'd0, column}) + $signed({x_offset[31], x_offset});
	assign sum_y = $signed({21'd0, row}) + $signed({y_offset[31], y_offset});
	assign tx = {rx_q, dx_q[32]};
	assign ty = {ry_q, dy_q[32]};
	assign gex = tx >= {1'b0, zoom};
	assign gey = ty >= {1'b0, zoom};
	assign out_data = {col_q, row_q, coord(qx_q, sx_q), coord(qy_q, sy_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= F_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = F_DIV;
			end
			F_DIV: if (step_q == CW'(DN - 1)) state_d = F_PUSH;
			F_PUSH: begin
				out_valid = 1'b1;
				if (out_ready) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			col_q <= column;
			row_q <= row;
			sx_q <= sum_x[32];
			sy_q <= sum_y[32];
			dx_q <= sum_x[32] ? 33'(-sum_x) : 33'(sum_x);
			dy_q <= sum_y[32] ? 33'(-sum_y) : 33'(sum_y);
			rx_q <= '0;
			ry_q <= '0;
			step_q <= '0;
		end else if (state_q == F_DIV) begin
			rx_q <= gex ? 31'(tx - {1'b0, zoom}) : tx[30:0];
			ry_q <= gey ? 31'(ty - {1'b0, zoom}) : ty[30:0];
			qx_q <= {qx_q[DN-2:0], gex};
			qy_q <= {qy_q[DN-2:0], gey};
			dx_q <= {dx_q[31:0], 1'b0};
			dy_q <= {dy_q[31:0], 1'b0};
			step_q <= step_q + 1'b1;
		end
	end
endmodule

// ===== hdl/met_queue.sv =====
// two entry queue between the front and the back end
// depends on met_pkg
`timescale 1ns / 1ps
module met_queue import met_pkg::*; #(
	parameter int DW = 120
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [DW-1:0] in_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [DW-1:0] out_data
);
	logic [DW-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end
endmodule

// ===== hdl/met_back.sv =====
// back end: iterates z = z*z + c on a shared multiplier and grades the count
// depends on met_pkg
`timescale 1ns / 1ps
module met_back import met_pkg::*; #(
	parameter int FRACTION_BITS = 40
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2*PIX_BITS+2*(FRACTION_BITS+8)-1:0] in_data,
	input  logic [CNT_BITS-1:0] limit,
	output logic out_valid,
	input  logic out_ready,
	output result_t out_result
);
	localparam int W = FRACTION_BITS + 8;
	localparam int M = FRACTION_BITS + 7;
	localparam int H = (M + 1) / 2;
	localparam int AW = 4 * H;
	localparam logic [W-1:0] MAXV = {1'b0, {M{1'b1}}};
	localparam logic signed [W:0] MAXE = {2'b00, {M{1'b1}}};
	localparam logic signed [W-1:0] ESC = {{(W-4){1'b0}}, 4'd9} << FRACTION_BITS;

	back_state_t state_q, state_d;
	mul_op_t op_q;
	logic signed [W-1:0] cre_q, cim_q, re_q, im_q, rr_q, ii_q, ri_q, t_q;
	logic [PIX_BITS-1:0] col_q, row_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [2:0] step_q, gstep_q;
	logic [1:0] pk_s1;
	logic [2*H-1:0] pp_s1;
	logic [AW-1:0] acc_q, sh;
	logic [19:0] rem_q, cmp;
	logic [7:0] gq_q;
	logic ovalid_q;
	result_t ores_q;
	logic signed [W-1:0] a_sel, b_sel, res_val;
	logic [W-1:0] am, bm;
	logic [2*H-1:0] ax, bx;
	logic [H-1:0] ah, bh;
	logic [M-1:0] res_mag;
	logic res_neg, escape, load_out;

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s > MAXE) return MAXV;
		else if (s < -MAXE) return -MAXV;
		else return s[W-1:0];
	endfunction

	assign a_sel = (op_q == OP_II0 || op_q == OP_II) ? im_q : re_q;
	assign b_sel = (op_q == OP_RR0 || op_q == OP_RR) ? re_q : im_q;
	assign am = a_sel[W-1] ? -a_sel : a_sel;
	assign bm = b_sel[W-1] ? -b_sel : b_sel;
	assign ax = (2*H)'(am[M-1:0]);
	assign bx = (2*H)'(bm[M-1:0]);
	assign ah = step_q[1] ? ax[2*H-1:H] : ax[H-1:0];
	assign bh = (step_q[1:0] == 2'd1 || step_q[1:0] == 2'd3) ? bx[2*H-1:H] : bx[H-1:0];

	assign sh = (op_q == OP_RI) ? acc_q >> (FRACTION_BITS - 1) : acc_q >> FRACTION_BITS;
	assign res_mag = (|sh[AW-1:M]) ? {M{1'b1}} : sh[M-1:0];
	assign res_neg = (op_q == OP_RI) && (re_q[W-1] != im_q[W-1]);
	assign res_val = res_neg ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
	assign escape = sat_add(rr_q, ii_q) > ESC;
	assign cmp = 20'(limit) << gstep_q;
	assign load_out = (state_q == B_FIN) && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;
	assign out_result = ores_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = B_MUL;
			end
			B_MUL: if (step_q == 3'd4) state_d = B_RES;
			B_RES: state_d = (op_q == OP_RI) ? B_UPD1 : (op_q == OP_II) ? B_CHK : B_MUL;
			B_UPD1: state_d = B_UPD2;
			B_UPD2: state_d = B_MUL;
			B_CHK: state_d = (escape || cnt_q == limit) ? B_GRAY : B_MUL;
			B_GRAY: if (gstep_q == 3'd0) state_d = B_FIN;
			B_FIN: if (load_out) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		pp_s1 <= (2*H)'(ah) * (2*H)'(bh);
		pk_s1 <= step_q[1:0];
		if (state_q == B_MUL) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd0) acc_q <= '0;
			else if (pk_s1 == 2'd0) acc_q <= acc_q + AW'(pp_s1);
			else if (pk_s1 == 2'd3) acc_q <= acc_q + (AW'(pp_s1) << (2*H));
			else acc_q <= acc_q + (AW'(pp_s1) << H);
		end else begin
			step_q <= 3'd0;
		end
		unique case (state_q)
			B_IDLE: if (in_valid) begin
				col_q <= in_data[2*W+2*PIX_BITS-1 -: PIX_BITS];
				row_q <= in_data[2*W+PIX_BITS-1 -: PIX_BITS];
				cre_q <= in_data[2*W-1 -: W];
				re_q <= in_data[2*W-1 -: W];
				cim_q <= in_data[W-1:0];
				im_q <= in_data[W-1:0];
				cnt_q <= '0;
				op_q <= OP_RR0;
			end
			B_RES: begin
				case (op_q)
					OP_RR0, OP_RR: rr_q <= res_val;
					OP_II0, OP_II: ii_q <= res_val;
					default: ri_q <= res_val;
				endcase
				case (op_q)
					OP_RR0: op_q <= OP_II0;
					OP_II0: op_q <= OP_RI;
					OP_RR: op_q <= OP_II;
					default: op_q <= op_q;
				endcase
			end
			B_UPD1: begin
				t_q <= sat_add(rr_q, -ii_q);
				im_q <= sat_add(ri_q, cim_q);
			end
			B_UPD2: begin
				re_q <= sat_add(t_q, cre_q);
				cnt_q <= cnt_q + 1'b1;
				op_q <= OP_RR;
			end
			B_CHK: begin
				op_q <= OP_RI;
				rem_q <= {cnt_q, 8'd0} - 20'(cnt_q);
				gq_q <= '0;
				gstep_q <= 3'd7;
			end
			B_GRAY: begin
				if (rem_q >= cmp) begin
					rem_q <= rem_q - cmp;
					gq_q[gstep_q] <= 1'b1;
				end
				gstep_q <= gstep_q - 3'd1;
			end
			B_FIN: if (load_out) begin
				ores_q.col <= col_q;
				ores_q.row <= row_q;
				ores_q.count <= cnt_q;
				ores_q.gray <= gq_q;
			end
			default: ;
		endcase
	end
endmodule

// ===== hdl/mandelbrot_escape_time_core.sv =====
// top level of the mandelbrot escape time core: registers, front, queue, back
// depends on met_pkg, met_front, met_queue, met_back and the macros header
//
// channel   | dir | fields (low bit up)
// s_axis    | in  | tdata: column[11:0], row[23:12]
// m_axis    | out | tdata: out_column, out_row, iteration_count, gray_level, pad to 48
// cfg       | in  | cfg_we, cfg_addr (register index), cfg_wdata
//
// front: takes a new pixel only once the bit serial coordinate divider has handed on the last
// back: takes a new pixel only when idle, iterates on the shared 4 pass multiplier,
// then runs the serial gray level division
// a two entry queue lets the front take new pixels while the back iterates
// output register holds a result until taken; the back stalls behind it
// asynchronous active low reset clears control state and loads register defaults
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_core_macros.svh"
module mandelbrot_escape_time_core import met_pkg::*; #(
	parameter int FRACTION_BITS = 40
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata, // column, row
	output logic m_tvalid,
	input  logic m_tready,
	output logic [47:0] m_tdata, // out_column, out_row, iteration_count, gray_level
	input  logic cfg_we,
	input  logic [1:0] cfg_addr,
	input  logic [31:0] cfg_wdata
);
	localparam int DW = 2 * PIX_BITS + 2 * (FRACTION_BITS + 8);

	logic [31:0] x_offset_q, y_offset_q;
	logic [30:0] zoom_q;
	logic [11:0] max_iter_q;
	logic [CNT_BITS-1:0] limit;
	logic f_valid, f_ready, b_valid, b_ready;
	logic [DW-1:0] f_data, b_data;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= -32'sd640;
			y_offset_q <= -32'sd360;
			zoom_q <= 31'd256;
			max_iter_q <= 12'd100;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_X_OFFSET: x_offset_q <= cfg_wdata;
				CFG_Y_OFFSET: y_offset_q <= cfg_wdata;
				CFG_ZOOM: zoom_q <= cfg_wdata[30:0];
				CFG_MAX_ITER: max_iter_q <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	assign limit = (max_iter_q == 12'd0) ? 12'd1 :
		(32'(max_iter_q) > ITERATION_LIMIT) ? CNT_BITS'(ITERATION_LIMIT) : max_iter_q;

	met_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.column(s_tdata[11:0]), .row(s_tdata[23:12]),
		.x_offset(x_offset_q), .y_offset(y_offset_q), .zoom_divisor(zoom_q),
		.out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
	);

	met_queue #(.DW(DW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
	);

	met_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_valid), .in_ready(b_ready), .in_data(b_data),
		.limit(limit),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_result(res)
	);

	assign m_tdata = {4'd0, res};

	`MET_ASSERT_IMP(a_count_nonzero, clk, arst_n, m_tvalid, m_tdata[35:24] != 12'd0)
	`MET_ASSERT_IMP(a_count_in_limit, clk, arst_n, m_tvalid, m_tdata[35:24] <= limit)
	`MET_ASSERT_IMP(a_full_gray, clk, arst_n, m_tvalid && m_tdata[35:24] == limit, m_tdata[43:36] == 8'd255)
	`MET_ASSERT_NXT(a_front_busy, clk, arst_n, s_tvalid && s_tready, !s_tready)
endmodule
